### rtl/hid_keyboard_report_merger_defines.svh
// assertion helpers for the report merger
`ifndef HID_KEYBOARD_REPORT_MERGER_DEFINES_SVH
`define HID_KEYBOARD_REPORT_MERGER_DEFINES_SVH

// property checked every clock, held off during reset
`define HKRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define HKRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hkrm_pkg.sv
`default_nettype none

package hkrm_pkg;

    localparam int MAX_SLOTS = 6;
    localparam int CNT_W     = 3;

    localparam logic [1:0] KIND_STORE       = 2'd0;
    localparam logic [1:0] KIND_RELEASE     = 2'd1;
    localparam logic [1:0] KIND_RELEASE_ALL = 2'd2;

    typedef struct packed {
        logic [7:0]                  mods;
        logic [MAX_SLOTS-1:0][7:0]   keys;
    } report_t;

    typedef struct packed {
        logic       clear;
        logic       push;
        logic [7:0] key;
    } coll_ctrl_t;

    typedef struct packed {
        logic                        roll;
        logic                        over;
        logic [CNT_W-1:0]            count;
        logic [MAX_SLOTS-1:0][7:0]   keys;
    } coll_status_t;

endpackage

`default_nettype wire

### rtl/hid_keyboard_report_merger.sv
// channel  dir  handshake              payload
// in       in   in_valid / in_stall    kind source modifiers_in key_in_0..key_in_5
// out      out  out_valid / out_stall  accepted changed modifiers_out key_out_0..key_out_5
// cfg      in   cfg_valid / cfg_ready  cfg_data (keyboard_source_mask)
//
// a store or release of a keyboard source walks the snapshot memory: one read per
// source, then one keycode per cycle into the collector, then the merged report
// is compared with the held one and the result registers in the publish state
// every other item goes straight from idle to publish, where its result registers
// reset clears the per-entry valid bits, the held report and sets the mask to all ones
// a result stalled at the output holds; the next item is taken once the previous
// result has moved into the output register
`default_nettype none
`include "hid_keyboard_report_merger_defines.svh"

module hid_keyboard_report_merger #(
    parameter int SOURCES       = 8,
    parameter int KEY_SLOTS     = 6,
    parameter int ROLLOVER_CODE = 1
) (
    input  wire        clk,
    input  wire        rst_n,

    input  wire        in_valid,
    output logic       in_stall,
    input  wire [1:0]  kind,
    input  wire [3:0]  source,
    input  wire [7:0]  modifiers_in,
    input  wire [7:0]  key_in_0,
    input  wire [7:0]  key_in_1,
    input  wire [7:0]  key_in_2,
    input  wire [7:0]  key_in_3,
    input  wire [7:0]  key_in_4,
    input  wire [7:0]  key_in_5,

    output logic       out_valid,
    input  wire        out_stall,
    output logic       accepted,
    output logic       changed,
    output logic [7:0] modifiers_out,
    output logic [7:0] key_out_0,
    output logic [7:0] key_out_1,
    output logic [7:0] key_out_2,
    output logic [7:0] key_out_3,
    output logic [7:0] key_out_4,
    output logic [7:0] key_out_5,

    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [7:0]  cfg_data
);

    localparam int IDX_W   = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int KS_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int ENTRY_W = 8 + 8 * KEY_SLOTS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_KEYS,
        S_DONE,
        S_PUBLISH
    } state_t;

    state_t                  state_reg;
    logic [7:0]              mask_reg;
    logic [SOURCES-1:0]      vld_reg;
    logic [IDX_W-1:0]        src_cnt_reg;
    logic [KS_W-1:0]         kslot_reg;
    logic                    ent_use_reg;
    logic [7:0]              mods_acc_reg;
    logic                    acc_reg;
    logic                    chg_reg;
    hkrm_pkg::report_t       current_report_reg;

    logic                    out_valid_reg;
    logic                    out_acc_reg;
    logic                    out_chg_reg;
    hkrm_pkg::report_t       out_report_reg;

    logic [ENTRY_W-1:0]      snap_mem [SOURCES];
    logic [ENTRY_W-1:0]      rd_data_reg;

    logic                    in_fire;
    logic                    src_ok;
    logic                    src_kb;
    logic [IDX_W-1:0]        wr_idx;
    logic [ENTRY_W-1:0]      wr_data;
    logic                    mem_we;
    logic                    mem_re;
    logic [3:0]              cnt_src4;
    logic                    cnt_kb;
    logic [7:0]              cur_key;
    logic [7:0]              key_in_arr [hkrm_pkg::MAX_SLOTS];
    hkrm_pkg::report_t       merged;
    hkrm_pkg::coll_ctrl_t    coll_ctrl;
    hkrm_pkg::coll_status_t  coll_st;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign key_in_arr[0] = key_in_0;
    assign key_in_arr[1] = key_in_1;
    assign key_in_arr[2] = key_in_2;
    assign key_in_arr[3] = key_in_3;
    assign key_in_arr[4] = key_in_4;
    assign key_in_arr[5] = key_in_5;

    // mask only covers sources one to eight
    assign src_ok = (source != 4'd0) && (source <= 4'(SOURCES));
    assign src_kb = src_ok && (source <= 4'd8) && mask_reg[3'(source - 4'd1)];
    assign wr_idx = IDX_W'(source - 4'd1);

    assign cnt_src4 = 4'(src_cnt_reg);
    assign cnt_kb   = (cnt_src4 < 4'd8) && mask_reg[cnt_src4[2:0]];

    always_comb
    begin
        wr_data[7:0] = modifiers_in;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            wr_data[8 + 8*i +: 8] = key_in_arr[i];
        end
    end

    assign mem_we  = in_fire && (kind == hkrm_pkg::KIND_STORE) && src_kb;
    assign mem_re  = (state_reg == S_READ);
    assign cur_key = rd_data_reg[8 + 8*kslot_reg +: 8];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            snap_mem[wr_idx] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= snap_mem[src_cnt_reg];
        end
    end

    always_comb
    begin
        coll_ctrl.clear = in_fire;
        coll_ctrl.push  = (state_reg == S_KEYS) && ent_use_reg;
        coll_ctrl.key   = cur_key;
    end

    hkrm_key_collector #(
        .KEY_SLOTS     (KEY_SLOTS),
        .ROLLOVER_CODE (ROLLOVER_CODE)
    ) u_collector (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (coll_ctrl),
        .status (coll_st)
    );

    always_comb
    begin
        merged.mods = mods_acc_reg;
        for (int i = 0; i < hkrm_pkg::MAX_SLOTS; i++)
        begin
            merged.keys[i] = 8'd0;
            if (i < KEY_SLOTS)
            begin
                merged.keys[i] = (coll_st.roll || coll_st.over) ? 8'(ROLLOVER_CODE)
                                                                : coll_st.keys[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            mask_reg           <= 8'hFF;
            vld_reg            <= '0;
            current_report_reg <= '0;
            out_valid_reg      <= 1'b0;
            src_cnt_reg        <= '0;
            kslot_reg          <= '0;
            acc_reg            <= 1'b0;
            chg_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mask_reg <= cfg_data;
            end
            // in publish the output register is either reloaded or left alone
            if (out_valid_reg && !out_stall && (state_reg != S_PUBLISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        chg_reg     <= 1'b0;
                        src_cnt_reg <= '0;
                        kslot_reg   <= '0;
                        case (kind)
                            hkrm_pkg::KIND_STORE:
                            begin
                                acc_reg <= src_kb;
                                if (src_kb)
                                begin
                                    vld_reg[wr_idx] <= 1'b1;
                                    state_reg       <= S_READ;
                                end
                                else
                                begin
                                    state_reg <= S_PUBLISH;
                                end
                            end
                            hkrm_pkg::KIND_RELEASE:
                            begin
                                acc_reg <= src_ok;
                                if (src_kb)
                                begin
                                    vld_reg[wr_idx] <= 1'b0;
                                    state_reg       <= S_READ;
                                end
                                else
                                begin
                                    state_reg <= S_PUBLISH;
                                end
                            end
                            hkrm_pkg::KIND_RELEASE_ALL:
                            begin
                                acc_reg            <= 1'b1;
                                vld_reg            <= '0;
                                current_report_reg <= '0;
                                state_reg          <= S_PUBLISH;
                            end
                            default:
                            begin
                                acc_reg   <= 1'b0;
                                state_reg <= S_PUBLISH;
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    // entries never stored or released read as empty
                    ent_use_reg <= vld_reg[src_cnt_reg] && cnt_kb;
                    state_reg   <= S_KEYS;
                end
                S_KEYS:
                begin
                    if (kslot_reg == '0)
                    begin
                        mods_acc_reg <= ((src_cnt_reg == '0) ? 8'd0 : mods_acc_reg)
                                        | (ent_use_reg ? rd_data_reg[7:0] : 8'd0);
                    end
                    if (kslot_reg == KS_W'(KEY_SLOTS - 1))
                    begin
                        kslot_reg <= '0;
                        if (src_cnt_reg == IDX_W'(SOURCES - 1))
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            src_cnt_reg <= src_cnt_reg + 1'b1;
                            state_reg   <= S_READ;
                        end
                    end
                    else
                    begin
                        kslot_reg <= kslot_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    chg_reg            <= (merged != current_report_reg);
                    current_report_reg <= merged;
                    state_reg          <= S_PUBLISH;
                end
                S_PUBLISH:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_acc_reg    <= acc_reg;
                        out_chg_reg    <= chg_reg;
                        out_report_reg <= current_report_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = out_acc_reg;
    assign changed       = out_chg_reg;
    assign modifiers_out = out_report_reg.mods;
    assign key_out_0     = out_report_reg.keys[0];
    assign key_out_1     = out_report_reg.keys[1];
    assign key_out_2     = out_report_reg.keys[2];
    assign key_out_3     = out_report_reg.keys[3];
    assign key_out_4     = out_report_reg.keys[4];
    assign key_out_5     = out_report_reg.keys[5];

    `HKRM_ASSERT_NEXT(a_release_all_clears, in_fire && kind == hkrm_pkg::KIND_RELEASE_ALL,
        current_report_reg == '0 && vld_reg == '0, "release all left state behind")
    `HKRM_ASSERT_NEXT(a_store_sets_valid, mem_we, vld_reg[$past(wr_idx)],
        "stored entry not marked valid")
    `HKRM_ASSERT(a_count_bounded, coll_st.count <= hkrm_pkg::CNT_W'(KEY_SLOTS),
        "collector holds more keys than slots")
    `HKRM_ASSERT(a_changed_needs_accept, out_valid && changed |-> accepted,
        "changed reported for a refused item")

endmodule

`default_nettype wire

### rtl/hkrm_key_collector.sv
`default_nettype none

// keeps the distinct nonzero, non-rollover keycodes pushed since the last clear in ascending order, one key per cycle
module hkrm_key_collector #(
    parameter int KEY_SLOTS     = 6,
    parameter int ROLLOVER_CODE = 1
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire hkrm_pkg::coll_ctrl_t  ctrl,
    output hkrm_pkg::coll_status_t     status
);

    logic [7:0]                    keys_reg [KEY_SLOTS];
    logic [hkrm_pkg::CNT_W-1:0]    cnt_reg;
    logic                          roll_reg;
    logic                          over_reg;

    logic [KEY_SLOTS-1:0]          lt_vec;
    logic [KEY_SLOTS-1:0]          hit_vec;
    logic [hkrm_pkg::CNT_W-1:0]    pos;
    logic                          is_roll;
    logic                          fresh;
    logic [7:0]                    keys_next [KEY_SLOTS];

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            lt_vec[i]  = (hkrm_pkg::CNT_W'(i) < cnt_reg) && (keys_reg[i] < ctrl.key);
            hit_vec[i] = (hkrm_pkg::CNT_W'(i) < cnt_reg) && (keys_reg[i] == ctrl.key);
        end
        // list is sorted, so the keys below the new one form a prefix
        pos     = hkrm_pkg::CNT_W'($countones(lt_vec));
        is_roll = (ctrl.key == 8'(ROLLOVER_CODE));
        fresh   = ctrl.push && (ctrl.key != 8'd0) && !is_roll && (hit_vec == '0);
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (hkrm_pkg::CNT_W'(i) < pos)
            begin
                keys_next[i] = keys_reg[i];
            end
            else if (hkrm_pkg::CNT_W'(i) == pos)
            begin
                keys_next[i] = ctrl.key;
            end
            else if (i > 0)
            begin
                keys_next[i] = keys_reg[i-1];
            end
            else
            begin
                keys_next[i] = keys_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            roll_reg <= 1'b0;
            over_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            cnt_reg  <= '0;
            roll_reg <= 1'b0;
            over_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.push && is_roll)
            begin
                roll_reg <= 1'b1;
            end
            if (fresh && !over_reg)
            begin
                if (cnt_reg == hkrm_pkg::CNT_W'(KEY_SLOTS))
                begin
                    over_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctrl.clear && fresh && !over_reg && (cnt_reg != hkrm_pkg::CNT_W'(KEY_SLOTS)))
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                keys_reg[i] <= keys_next[i];
            end
        end
    end

    always_comb
    begin
        status.roll  = roll_reg;
        status.over  = over_reg;
        status.count = cnt_reg;
        for (int i = 0; i < hkrm_pkg::MAX_SLOTS; i++)
        begin
            status.keys[i] = 8'd0;
            if (i < KEY_SLOTS)
            begin
                if (hkrm_pkg::CNT_W'(i) < cnt_reg)
                begin
                    status.keys[i] = keys_reg[i];
                end
            end
        end
    end

endmodule

`default_nettype wire
